### hw/rtl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and codes for the particle population roulette block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

  localparam logic [1:0] ActSetup    = 2'd0;
  localparam logic [1:0] ActTally    = 2'd1;
  localparam logic [1:0] ActRoulette = 2'd2;
  localparam logic [1:0] ActRenorm   = 2'd3;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatZeroSw  = 2'd1;
  localparam logic [1:0] StatSat     = 2'd2;

  localparam int DvdW = 80;
  localparam int DivW = 48;
  localparam int QuoW = 32;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] act;
    logic [47:0] aw;
    logic [47:0] sw;
  } cell_t;

  typedef struct packed {
    logic            done;
    logic            sat;
    logic [QuoW-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

### hw/rtl/ppr_if.sv
// ----------------------------------------------------------------------------
// ppr_in_if / ppr_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] cell_req;
  logic [31:0] weight;
  logic [15:0] random_fraction;
  logic [15:0] source_count;

  modport source (output valid, action, cell_req, weight, random_fraction, source_count,
                  input ready);
  modport sink   (input valid, action, cell_req, weight, random_fraction, source_count,
                  output ready);
endinterface

interface ppr_out_if;
  logic        valid;
  logic        ready;
  logic        removed;
  logic [31:0] new_weight;
  logic [1:0]  status;

  modport source (output valid, removed, new_weight, status, input ready);
  modport sink   (input valid, removed, new_weight, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/ppr_div.sv
// ----------------------------------------------------------------------------
// ppr_div
// Restoring divider, one quotient bit a cycle, saturating at 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [ppr_pkg::DvdW-1:0] dividend_i,
  input  wire logic [ppr_pkg::DivW-1:0] divisor_i,
  output ppr_pkg::div_res_t            res_o
);

  localparam int CntW = $clog2(ppr_pkg::DvdW);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [ppr_pkg::DvdW-1:0]  dvd_q, dvd_d;
  logic [ppr_pkg::DivW-1:0]  dsr_q, dsr_d;
  logic [ppr_pkg::DivW-1:0]  rem_q, rem_d;
  logic [ppr_pkg::QuoW-1:0]  quo_q, quo_d;
  logic                      sat_q, sat_d;
  logic [ppr_pkg::DivW:0]    rem_sh;
  logic                      qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    rem_sh = {rem_q, dvd_q[ppr_pkg::DvdW-1]};
    qbit   = rem_sh >= {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(ppr_pkg::DvdW - 1);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = qbit ? ppr_pkg::DivW'(rem_sh - {1'b0, dsr_q}) : rem_sh[ppr_pkg::DivW-1:0];
      dvd_d = {dvd_q[ppr_pkg::DvdW-2:0], 1'b0};
      // a bit shifted out of the top means the quotient no longer fits
      sat_d = sat_q | quo_q[ppr_pkg::QuoW-1];
      quo_d = {quo_q[ppr_pkg::QuoW-2:0], qbit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quot = quo_q;

endmodule

`default_nettype wire

### hw/rtl/particle_population_roulette.sv
// ----------------------------------------------------------------------------
// particle_population_roulette
// Per-cell population control: setup, tally, roulette and renormalise
// against a cell table held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    action, cell_req, weight, random_fraction,
//                               source_count
//  out_o    out  valid/ready    removed, new_weight, status
//  apb      in   psel/penable   kill_factor, at any address
//
//  Setup, tally and roulette do a table read, then modify, write back and
//  result. Renormalise adds a registered partial product and the 80-step
//  divider. Where CELL_COUNT is below 4096 an out-of-range cell index is
//  first reduced modulo CELL_COUNT in StRed. Items are taken only in idle.
//  No clearing pass after reset. A result waiting at the output holds back
//  only the next result, not the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_population_roulette #(
  parameter int CELL_COUNT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ppr_in_if.sink           in_i,
  ppr_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CW = 12 + $clog2(CELL_COUNT + 1) + 1;
  localparam bit NeedRed = CELL_COUNT < 4096;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed  = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] st_q, st_d;

  // configuration
  logic [3:0] kf_q;
  assign pready = 1'b1;
  assign prdata = {28'd0, kf_q};
  // paddr is not decoded; every address reaches the single register word
  logic       unused_addr;
  assign unused_addr = ^paddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kf_q <= 4'd4;
    end else if (psel && penable && pwrite) begin
      kf_q <= pwdata[3:0];
    end
  end

  // captured item
  logic [1:0]  act_q;
  logic [31:0] w_q;
  logic [15:0] rnd_q, src_q;
  logic [11:0] rem_q, rem_d;
  logic [3:0]  k_q, k_d;
  logic [AW-1:0] addr_q;

  // cell table
  ppr_pkg::cell_t mem [CELL_COUNT];
  ppr_pkg::cell_t rdata_q;
  logic           rd_en, we;
  logic [AW-1:0]  rd_addr;
  ppr_pkg::cell_t wdata;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (we) begin
      mem[addr_q] <= wdata;
    end
  end

  logic [CW-1:0] req_w, rem_w, trial, step_w;
  logic          accept, need_red;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == StIdle);
  assign req_w    = CW'(in_i.cell_req);
  assign need_red = NeedRed && (req_w >= CW'(CELL_COUNT));
  assign rem_w    = CW'(rem_q);
  assign trial    = CW'(CELL_COUNT) << k_q;
  assign step_w   = (rem_w >= trial) ? rem_w - trial : rem_w;

  // product stage and divider
  logic [63:0] p0_q;
  logic [47:0] p1;
  logic        div_start;
  logic [ppr_pkg::DvdW-1:0] dividend;
  ppr_pkg::div_res_t div_res;

  assign p1       = w_q * rdata_q.aw[47:32];
  assign dividend = ppr_pkg::DvdW'(p0_q) + {p1, 32'd0};

  ppr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (rdata_q.sw),
    .res_o      (div_res)
  );

  // execute stage
  logic [31:0] thr;
  logic [31:0] lhs, rhs;
  logic [16:0] dif;
  logic [48:0] aw_sum, sw_sum;
  logic        kill, cnt_sat;
  logic        fin, ld_p0;
  logic        r_rem;
  logic [31:0] r_nw;
  logic [1:0]  r_st;
  logic        res_rem_q;
  logic [31:0] res_nw_q;
  logic [1:0]  res_st_q;
  logic        out_free;

  logic        ov_q;
  logic        o_rem_q;
  logic [31:0] o_nw_q;
  logic [1:0]  o_st_q;

  assign out_free = !ov_q || out_o.ready;

  always_comb begin
    thr     = 32'(kf_q) * 32'(rdata_q.src);
    dif     = 17'({1'b0, rdata_q.act}) - 17'(thr[19:0]);
    lhs     = rnd_q * rdata_q.act;
    rhs     = {dif[15:0], 16'd0};
    kill    = (32'(rdata_q.act) > thr) && (lhs < rhs);
    aw_sum  = 49'(rdata_q.aw) + 49'(w_q);
    sw_sum  = 49'(rdata_q.sw) + 49'(w_q);
    cnt_sat = rdata_q.act == 16'hFFFF;

    st_d      = st_q;
    rem_d     = rem_q;
    k_d       = k_q;
    rd_en     = 1'b0;
    rd_addr   = addr_q;
    we        = 1'b0;
    wdata     = rdata_q;
    div_start = 1'b0;
    ld_p0     = 1'b0;
    fin       = 1'b0;
    r_rem     = 1'b0;
    r_nw      = w_q;
    r_st      = ppr_pkg::StatOk;

    unique case (st_q)
      StIdle: begin
        if (accept) begin
          rem_d = in_i.cell_req;
          k_d   = 4'd11;
          if (need_red) begin
            st_d = StRed;
          end else begin
            rd_en   = 1'b1;
            rd_addr = req_w[AW-1:0];
            st_d    = StExec;
          end
        end
      end
      StRed: begin
        rem_d = step_w[11:0];
        k_d   = k_q - 4'd1;
        if (k_q == 4'd0) begin
          rd_en   = 1'b1;
          rd_addr = step_w[AW-1:0];
          st_d    = StExec;
        end
      end
      StExec: begin
        case (act_q)
          ppr_pkg::ActSetup: begin
            we    = 1'b1;
            wdata = '{src: src_q, act: 16'd0, aw: 48'd0, sw: 48'd0};
            fin   = 1'b1;
          end
          ppr_pkg::ActTally: begin
            we        = 1'b1;
            wdata.act = cnt_sat ? rdata_q.act : rdata_q.act + 16'd1;
            wdata.aw  = aw_sum[48] ? 48'hFFFF_FFFF_FFFF : aw_sum[47:0];
            fin       = 1'b1;
            if (cnt_sat || aw_sum[48]) r_st = ppr_pkg::StatSat;
          end
          ppr_pkg::ActRoulette: begin
            fin   = 1'b1;
            r_rem = kill;
            if (!kill) begin
              we       = 1'b1;
              wdata.sw = sw_sum[48] ? 48'hFFFF_FFFF_FFFF : sw_sum[47:0];
              if (sw_sum[48]) r_st = ppr_pkg::StatSat;
            end
          end
          default: begin
            if (rdata_q.sw == 48'd0) begin
              fin  = 1'b1;
              r_st = ppr_pkg::StatZeroSw;
            end else begin
              ld_p0 = 1'b1;
              st_d  = StMul;
            end
          end
        endcase
      end
      StMul: begin
        div_start = 1'b1;
        st_d      = StDiv;
      end
      StDiv: begin
        if (div_res.done) begin
          fin  = 1'b1;
          r_nw = div_res.sat ? 32'hFFFF_FFFF : div_res.quot;
          r_st = div_res.sat ? ppr_pkg::StatSat : ppr_pkg::StatOk;
        end
      end
      StOut: begin
        if (out_free) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase

    if (fin) st_d = out_free ? StIdle : StOut;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if ((fin || st_q == StOut) && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    k_q   <= k_d;
    if (accept) begin
      act_q <= in_i.action;
      w_q   <= in_i.weight;
      rnd_q <= in_i.random_fraction;
      src_q <= in_i.source_count;
    end
    if (rd_en) addr_q <= rd_addr;
    if (ld_p0) p0_q <= w_q * rdata_q.aw[31:0];
    if (fin) begin
      res_rem_q <= r_rem;
      res_nw_q  <= r_nw;
      res_st_q  <= r_st;
    end
    if (fin && out_free) begin
      o_rem_q <= r_rem;
      o_nw_q  <= r_nw;
      o_st_q  <= r_st;
    end else if (st_q == StOut && out_free) begin
      o_rem_q <= res_rem_q;
      o_nw_q  <= res_nw_q;
      o_st_q  <= res_st_q;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.removed    = o_rem_q;
  assign out_o.new_weight = o_nw_q;
  assign out_o.status     = o_st_q;

endmodule

`default_nettype wire
